### rtl/nesc_pkg.sv
// nesc_pkg: shared constants, types and table functions of the noise envelope sound chip
// no dependencies; used by nesc_div, nesc_dp, nesc_ctrl and the top level
`default_nettype none
package nesc_pkg;

  // fixed point layout of the phase accumulators
  localparam int FRAC_BITS  = 26;
  localparam int RATE_W     = 32;
  localparam int CYC_W      = 22;
  localparam int DIVIDEND_W = 34;
  localparam int SHIFT_W    = RATE_W + 1 - FRAC_BITS;

  // envelope parts
  localparam logic [1:0] PART_OFF     = 2'd0;
  localparam logic [1:0] PART_SUSTAIN = 2'd1;
  localparam logic [1:0] PART_PAUSE   = 2'd2;
  localparam logic [1:0] PART_RELEASE = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_TICK_SCALE = 2'd0;
  localparam logic [1:0] REG_NOISE_LOW  = 2'd1;
  localparam logic [1:0] REG_NOISE_HIGH = 2'd2;
  localparam logic [1:0] REG_DELAY_RATE = 2'd3;

  // command nibbles
  localparam logic [3:0] CMD_START_A = 4'h1;
  localparam logic [3:0] CMD_START_B = 4'h2;
  localparam logic [3:0] CMD_FETCH_A = 4'h3;
  localparam logic [3:0] CMD_FETCH_B = 4'h4;
  localparam logic [3:0] CMD_FETCH_C = 4'h6;

  // fetch targets
  localparam logic [1:0] TGT_NONE = 2'd0;
  localparam logic [1:0] TGT_A    = 2'd1;
  localparam logic [1:0] TGT_B    = 2'd2;
  localparam logic [1:0] TGT_C    = 2'd3;

  localparam logic [14:0] LFSR_INIT = 15'h0fff;
  localparam logic [CYC_W-1:0] SUSTAIN_DEFAULT_CYCLES = CYC_W'(1003);

  localparam logic [CYC_W-1:0] BIT_CYCLES [8] = '{
    CYC_W'(19936), CYC_W'(29967), CYC_W'(49444), CYC_W'(89401),
    CYC_W'(168395), CYC_W'(327471), CYC_W'(645454), CYC_W'(1280209)
  };

  localparam logic [3:0] FADE_TABLE [16][8] = '{
    '{4'd0,  4'd0,  4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd1,  4'd0,  4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd2,  4'd1,  4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd3,  4'd2,  4'd1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd4,  4'd3,  4'd2, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd5,  4'd3,  4'd2, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd6,  4'd4,  4'd3, 4'd2, 4'd1, 4'd0, 4'd0, 4'd0},
    '{4'd7,  4'd5,  4'd3, 4'd2, 4'd1, 4'd0, 4'd0, 4'd0},
    '{4'd8,  4'd6,  4'd4, 4'd3, 4'd2, 4'd1, 4'd0, 4'd0},
    '{4'd9,  4'd6,  4'd4, 4'd3, 4'd2, 4'd1, 4'd0, 4'd0},
    '{4'd10, 4'd7,  4'd5, 4'd3, 4'd2, 4'd1, 4'd0, 4'd0},
    '{4'd11, 4'd7,  4'd6, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0},
    '{4'd12, 4'd9,  4'd6, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0},
    '{4'd13, 4'd9,  4'd6, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0},
    '{4'd14, 4'd10, 4'd7, 4'd5, 4'd3, 4'd2, 4'd1, 4'd0},
    '{4'd15, 4'd11, 4'd8, 4'd6, 4'd4, 4'd3, 4'd2, 4'd1}
  };

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic load_out;
    logic env_adv;
    logic env_ch;
    logic div_start;
    logic step_wr;
    logic noise_adv;
    logic shift;
    logic delay_adv;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic in_tick;
    logic in_start;
    logic out_free;
    logic need_div;
    logic shift_done;
    logic div_done;
  } dp_status_t;

  // chip cycles of one envelope part from its parameter byte
  function automatic logic [CYC_W-1:0] part_cycles(input logic [7:0] b, input logic sustain);
    logic [7:0] v;
    logic [CYC_W-1:0] acc;
    v = {b[3:0], b[7:4]};
    acc = '0;
    for (int j = 0; j < 8; j++) begin
      if (v[j]) acc = acc + BIT_CYCLES[j];
    end
    if (v == 8'd0) acc = sustain ? SUSTAIN_DEFAULT_CYCLES : CYC_W'(1);
    return acc;
  endfunction

  function automatic logic [3:0] fade_level(input logic [3:0] vol, input logic [2:0] idx);
    return FADE_TABLE[vol][idx];
  endfunction

endpackage
`default_nettype wire

### rtl/noise_envelope_sound_chip_top.sv
// noise_envelope_sound_chip_top: two-channel noise sound generator, top level
// depends on nesc_pkg, nesc_ctrl, nesc_dp (and nesc_div inside it)
//
//   port group   direction  handshake            payload
//   input        in         in_valid / in_ready   operation, data_byte
//   output       out        out_valid / out_ready level_a, level_b
//   config       in         cfg_we (no wait)      cfg_index, cfg_data
//
// a plain byte write leaves the controller idle; a channel start runs the divider first
// a tick also runs the serial divider once per envelope part change
//   and then the lfsr shifts (0 to 64, one shift per cycle)
// rst is synchronous; a tick stalls before its levels load while a result still waits
`default_nettype none
module noise_envelope_sound_chip_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        operation,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       level_a,
  output logic [3:0]       level_b,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import nesc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  nesc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  nesc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .operation (operation),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .level_a   (level_a),
    .level_b   (level_b),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // a tick request occupies the block once it is taken
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && operation) |=> !in_ready)
    else $error("tick request did not occupy the block");

  // levels only load into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> status.out_free)
    else $error("result overwritten before taken");

  // divider cannot finish right after a start
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !status.div_done)
    else $error("divider finished too early");

  // datapath steps never overlap
  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_out, cmd.env_adv, cmd.noise_adv, cmd.shift, cmd.delay_adv,
              cmd.step_wr}))
    else $error("overlapping datapath commands");

endmodule
`default_nettype wire

### rtl/nesc_div.sv
// nesc_div: restoring divider, one quotient bit per cycle, 32-bit saturated result
// depends on nesc_pkg
`default_nettype none
module nesc_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [nesc_pkg::DIVIDEND_W-1:0]   dividend,
  input  wire logic [nesc_pkg::CYC_W-1:0]        divisor,
  output logic                                   done,
  output logic [nesc_pkg::RATE_W-1:0]            quotient
);
  import nesc_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [CYC_W-1:0]      rem;
  logic [DIVIDEND_W-1:0] quo;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic [CYC_W:0]        rem_sh;
  logic [CYC_W:0]        rem_sub;
  logic                  fits;

  // one restoring step
  assign rem_sh  = {rem, quo[DIVIDEND_W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign fits    = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? rem_sub[CYC_W-1:0] : rem_sh[CYC_W-1:0];
      quo <= {quo[DIVIDEND_W-2:0], fits};
    end
  end

  // saturate to 32 bits
  assign quotient = (|quo[DIVIDEND_W-1:RATE_W]) ? '1 : quo[RATE_W-1:0];

endmodule
`default_nettype wire

### rtl/nesc_dp.sv
// nesc_dp: datapath with configuration, parameters, envelopes, noise source and output register
// depends on nesc_pkg and nesc_div
`default_nettype none
module nesc_dp (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire nesc_pkg::dp_cmd_t     cmd,
  output nesc_pkg::dp_status_t       status,
  input  wire logic                  operation,
  input  wire logic [7:0]            data_byte,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [3:0]                 level_a,
  output logic [3:0]                 level_b,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [31:0]           cfg_data
);
  import nesc_pkg::*;

  logic [23:0]        tick_scale;
  logic [RATE_W-1:0]  noise_rate_low;
  logic [RATE_W-1:0]  noise_rate_high;
  logic [RATE_W-1:0]  delay_rate;

  logic [7:0]           params_a [4];
  logic [7:0]           params_b [4];
  logic [2:0]           fetch_left;
  logic [1:0]           fetch_target;
  logic [FRAC_BITS-1:0] env_phase [2];
  logic [RATE_W-1:0]    env_step [2];
  logic [1:0]           env_part [2];
  logic [3:0]           env_volume [2];
  logic [2:0]           release_index [2];
  logic [14:0]          lfsr;
  logic [FRAC_BITS-1:0] noise_phase;
  logic [RATE_W-1:0]    delay_phase;
  logic                 noise_a;
  logic                 noise_b;
  logic                 b_pending;
  logic                 prev_noise;
  logic [SHIFT_W-1:0]   shift_cnt;
  logic [CYC_W-1:0]     div_cycles;
  logic                 div_ch;

  logic                 div_done;
  logic [RATE_W-1:0]    div_quo;
  logic [RATE_W:0]      env_sum;
  logic                 env_carry;
  logic [7:0]           sel_p1;
  logic [7:0]           sel_p2;
  logic [7:0]           sel_p3;
  logic [RATE_W:0]      noise_sum;
  logic [RATE_W:0]      delay_sum;
  logic                 start_hit;
  logic                 start_ch;
  logic [1:0]           fetch_idx;
  logic [3:0]           lvl_a;
  logic [3:0]           lvl_b;
  logic                 out_free;

  nesc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend ({tick_scale, 10'd0}),
    .divisor  (div_cycles),
    .done     (div_done),
    .quotient (div_quo)
  );

  // command decode of the incoming byte
  assign start_hit = (fetch_left == 3'd0) &&
                     ((data_byte[7:4] == CMD_START_A) || (data_byte[7:4] == CMD_START_B));
  assign start_ch  = (data_byte[7:4] == CMD_START_B);
  assign fetch_idx = 2'(3'd4 - fetch_left);

  // envelope phase step of the selected channel
  assign env_sum   = {{(RATE_W + 1 - FRAC_BITS){1'b0}}, env_phase[cmd.env_ch]} +
                     {1'b0, env_step[cmd.env_ch]};
  assign env_carry = |env_sum[RATE_W:FRAC_BITS];
  assign sel_p1    = cmd.env_ch ? params_b[1] : params_a[1];
  assign sel_p2    = cmd.env_ch ? params_b[2] : params_a[2];
  assign sel_p3    = cmd.env_ch ? params_b[3] : params_a[3];

  // noise and delay accumulators
  assign noise_sum = {{(RATE_W + 1 - FRAC_BITS){1'b0}}, noise_phase} +
                     {1'b0, (noise_a ? noise_rate_high : noise_rate_low)};
  assign delay_sum = {1'b0, delay_phase} + {1'b0, delay_rate};

  // levels before advancing
  always_comb begin
    lvl_a = 4'd0;
    lvl_b = 4'd0;
    if (env_part[0] == PART_SUSTAIN) lvl_a = env_volume[0];
    else if (env_part[0] == PART_RELEASE) lvl_a = fade_level(env_volume[0], release_index[0]);
    if (env_part[1] == PART_SUSTAIN) lvl_b = env_volume[1];
    else if (env_part[1] == PART_RELEASE) lvl_b = fade_level(env_volume[1], release_index[1]);
    if (!noise_a) lvl_a = 4'd0;
    if (!noise_b) lvl_b = 4'd0;
  end

  assign out_free = !out_valid || out_ready;

  always_comb begin
    status.in_tick    = operation;
    status.in_start   = !operation && start_hit;
    status.out_free   = out_free;
    status.need_div   = env_carry &&
                        ((env_part[cmd.env_ch] == PART_SUSTAIN) ||
                         (env_part[cmd.env_ch] == PART_PAUSE) ||
                         ((env_part[cmd.env_ch] == PART_RELEASE) &&
                          (release_index[cmd.env_ch] != 3'd7)));
    status.shift_done = (shift_cnt == '0);
    status.div_done   = div_done;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_scale      <= 24'd2739137;
      noise_rate_low  <= 32'd5165518;
      noise_rate_high <= 32'd3944974;
      delay_rate      <= 32'd13420462;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TICK_SCALE: tick_scale      <= cfg_data[23:0];
        REG_NOISE_LOW:  noise_rate_low  <= cfg_data;
        REG_NOISE_HIGH: noise_rate_high <= cfg_data;
        REG_DELAY_RATE: delay_rate      <= cfg_data;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      level_a <= lvl_a;
      level_b <= lvl_b;
    end
  end

  // parameters, fetch and envelopes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        params_a[i] <= 8'd0;
        params_b[i] <= 8'd0;
      end
      fetch_left   <= 3'd0;
      fetch_target <= TGT_NONE;
      for (int i = 0; i < 2; i++) begin
        env_phase[i]     <= '0;
        env_step[i]      <= '0;
        env_part[i]      <= PART_OFF;
        env_volume[i]    <= 4'd0;
        release_index[i] <= 3'd0;
      end
      div_cycles <= '0;
      div_ch     <= 1'b0;
    end else begin
      if (cmd.accept && !operation) begin
        if (fetch_left != 3'd0) begin
          // parameter bytes; the bytes of fetch c are only counted
          if ((fetch_target != TGT_C) && (fetch_left <= 3'd4)) begin
            if (fetch_target == TGT_B) params_b[fetch_idx] <= data_byte;
            else params_a[fetch_idx] <= data_byte;
          end
          fetch_left <= fetch_left - 3'd1;
        end else if (start_hit) begin
          env_part[start_ch]   <= PART_SUSTAIN;
          env_phase[start_ch]  <= '0;
          env_volume[start_ch] <= start_ch ? params_b[3][7:4] : params_a[3][7:4];
          div_cycles <= part_cycles(start_ch ? params_b[0] : params_a[0], 1'b1);
          div_ch     <= start_ch;
        end else begin
          unique case (data_byte[7:4])
            CMD_FETCH_A: begin
              fetch_left   <= 3'd4;
              fetch_target <= TGT_A;
            end
            CMD_FETCH_B: begin
              fetch_left   <= 3'd4;
              fetch_target <= TGT_B;
            end
            CMD_FETCH_C: begin
              fetch_left   <= 3'd5;
              fetch_target <= TGT_C;
            end
            default: ;
          endcase
        end
      end
      if (cmd.env_adv) begin
        env_phase[cmd.env_ch] <= env_sum[FRAC_BITS-1:0];
        div_ch <= cmd.env_ch;
        if (env_carry) begin
          unique case (env_part[cmd.env_ch])
            PART_SUSTAIN: begin
              env_part[cmd.env_ch]   <= PART_PAUSE;
              env_volume[cmd.env_ch] <= 4'd0;
              div_cycles <= part_cycles(sel_p1, 1'b0);
            end
            PART_PAUSE: begin
              env_part[cmd.env_ch]      <= PART_RELEASE;
              env_volume[cmd.env_ch]    <= sel_p3[3:0];
              release_index[cmd.env_ch] <= 3'd0;
              div_cycles <= part_cycles(sel_p2, 1'b0);
            end
            PART_RELEASE: begin
              if (release_index[cmd.env_ch] != 3'd7) begin
                release_index[cmd.env_ch] <= release_index[cmd.env_ch] + 3'd1;
                div_cycles <= part_cycles(sel_p2, 1'b0);
              end else begin
                env_part[cmd.env_ch] <= PART_OFF;
              end
            end
            default: ;
          endcase
        end
      end
      if (cmd.step_wr) env_step[div_ch] <= div_quo;
    end
  end

  // noise source and channel b delay
  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr        <= LFSR_INIT;
      noise_phase <= '0;
      delay_phase <= '0;
      noise_a     <= 1'b1;
      noise_b     <= 1'b0;
      b_pending   <= 1'b0;
      prev_noise  <= 1'b0;
      shift_cnt   <= '0;
    end else begin
      if (cmd.noise_adv) begin
        shift_cnt   <= noise_sum[RATE_W:FRAC_BITS];
        noise_phase <= noise_sum[FRAC_BITS-1:0];
        if (!b_pending) delay_phase <= {{(RATE_W - FRAC_BITS){1'b0}}, noise_sum[FRAC_BITS-1:0]};
      end
      if (cmd.shift) begin
        noise_a    <= lfsr[0];
        prev_noise <= lfsr[0];
        // falling edge of channel a toggles the delay arm
        if (prev_noise && !lfsr[0]) b_pending <= !b_pending;
        lfsr      <= {lfsr[0] ^ lfsr[11], lfsr[14:1]};
        shift_cnt <= shift_cnt - SHIFT_W'(1);
      end
      if (cmd.delay_adv && b_pending) begin
        delay_phase <= delay_sum[RATE_W-1:0];
        if (|delay_sum[RATE_W:FRAC_BITS]) begin
          noise_b   <= !noise_b;
          b_pending <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

### rtl/nesc_ctrl.sv
// nesc_ctrl: controller that sequences writes and sample ticks through the datapath
// depends on nesc_pkg
`default_nettype none
module nesc_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire nesc_pkg::dp_status_t  status,
  output nesc_pkg::dp_cmd_t          cmd
);
  import nesc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_OUT   = 3'd1;
  localparam logic [2:0] S_ENV   = 3'd2;
  localparam logic [2:0] S_DIVL  = 3'd3;
  localparam logic [2:0] S_DIVW  = 3'd4;
  localparam logic [2:0] S_NOISE = 3'd5;
  localparam logic [2:0] S_SHIFT = 3'd6;
  localparam logic [2:0] S_DELAY = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       ch;
  logic       ch_next;
  logic       tick;
  logic       tick_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ch_next    = ch;
    tick_next  = tick;
    cmd        = '0;
    cmd.env_ch = ch;
    unique case (state)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          if (status.in_tick) begin
            state_next = S_OUT;
            tick_next  = 1'b1;
          end else if (status.in_start) begin
            state_next = S_DIVL;
            tick_next  = 1'b0;
          end
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          ch_next      = 1'b0;
          state_next   = S_ENV;
        end
      end
      S_ENV: begin
        cmd.env_adv = 1'b1;
        if (status.need_div) state_next = S_DIVL;
        else if (!ch) ch_next = 1'b1;
        else state_next = S_NOISE;
      end
      S_DIVL: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIVW;
      end
      S_DIVW: begin
        if (status.div_done) begin
          cmd.step_wr = 1'b1;
          if (!tick) state_next = S_IDLE;
          else if (!ch) begin
            ch_next    = 1'b1;
            state_next = S_ENV;
          end else state_next = S_NOISE;
        end
      end
      S_NOISE: begin
        cmd.noise_adv = 1'b1;
        state_next    = S_SHIFT;
      end
      S_SHIFT: begin
        if (status.shift_done) state_next = S_DELAY;
        else cmd.shift = 1'b1;
      end
      S_DELAY: begin
        cmd.delay_adv = 1'b1;
        state_next    = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ch    <= 1'b0;
      tick  <= 1'b0;
    end else begin
      state <= state_next;
      ch    <= ch_next;
      tick  <= tick_next;
    end
  end

endmodule
`default_nettype wire
